// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the evaluator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/iee_pkg.sv =====
// Package with the codes, types and helper functions of the expression evaluator.
package iee_pkg;
  typedef enum logic [2:0] {
    OP_OPEN = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_REM = 3'd3,
    OP_MUL = 3'd4, OP_DIV = 3'd5, OP_CLOSE = 3'd7, OP_NONE = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIVZERO = 2'd1, ST_OVERFLOW = 2'd2, ST_MALFORMED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDOP, S_WAITOP, S_DECIDE, S_RDB, S_RDA, S_WAITA,
    S_DIVRUN, S_WRITE, S_FINAL, S_RDRES, S_WAITRES
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  function automatic op_t decode_ch(input logic [7:0] c);
    op_t o;
    unique case (c)
      CH_OPEN:  o = OP_OPEN;
      CH_CLOSE: o = OP_CLOSE;
      CH_PLUS:  o = OP_ADD;
      CH_MINUS: o = OP_SUB;
      CH_PCT:   o = OP_REM;
      CH_STAR:  o = OP_MUL;
      CH_SLASH: o = OP_DIV;
      default:  o = OP_NONE;
    endcase
    return o;
  endfunction

  function automatic logic [1:0] prec_of(input logic [2:0] o);
    logic [1:0] p;
    unique case (o)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_REM:         p = 2'd2;
      OP_MUL, OP_DIV: p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction
endpackage

// ===== hdl/infix_expression_evaluator.sv =====
// Top level of the two-stack infix expression evaluator.
// Usage: characters arrive as beats on in_ch with in_last marking the final one.
// A beat is taken when in_valid is high and in_stall is low.
// A digit or an ignored character that is not the last is taken without a stall.
// An opening bracket, an operator or a closing bracket stalls the input while the
// operator stack top is read and each reduction it triggers runs; a division or
// remainder reduction also waits for the shared bit-serial divider.
// On the last beat the remaining operators are reduced the same way, and the result
// beat then comes through S_FINAL, S_RDRES and S_WAITRES.
// After an error, beats are taken without a stall; the last one goes straight to S_FINAL.
// out_status is 0 ok, 1 divide by zero, 2 stack overflow, 3 malformed, and
// out_value is 0 on error.
// The stacks live in two single-port-write memories with registered reads, so
// every reduction is a read, read, compute, write sequence.
// Reset clears the counts, the pending number and the error; stack contents
// need no clearing. After each result the block returns to that state.
// If out_stall holds the result, it stays in the output register while new beats
// are taken; only the next result waits until the held one leaves.
module infix_expression_evaluator #(
  parameter int VALUE_DEPTH    = 16,
  parameter int OPERATOR_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_value,
  output logic [1:0]  out_status
);
  import iee_pkg::*;

  localparam int VW = $clog2(VALUE_DEPTH);
  localparam int OW = $clog2(OPERATOR_DEPTH);

  state_t state_r, state_nxt;
  logic [VW:0]  vcnt_r, vcnt_nxt;
  logic [OW:0]  ocnt_r, ocnt_nxt;
  logic [31:0]  pend_r, pend_nxt;
  logic         innum_r, innum_nxt;
  logic [1:0]   err_r, err_nxt;
  logic [2:0]   op_r, op_nxt;
  logic         last_r, last_nxt;
  logic [2:0]   top_r, top_nxt;
  logic [31:0]  b_r, b_nxt, res_r, res_nxt;
  logic         ov_r, ov_nxt;
  logic [31:0]  oval_r, oval_nxt;
  logic [1:0]   ost_r, ost_nxt;

  logic        v_we, o_we;
  logic [VW-1:0] v_waddr, v_raddr;
  logic [OW-1:0] o_waddr, o_raddr;
  logic [31:0] v_wdata, v_rdata;
  logic [2:0]  o_wdata, o_rdata;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        take;
  op_t         cop;
  logic [31:0] alu;

  iee_stacks #(.VALUE_DEPTH(VALUE_DEPTH), .OPERATOR_DEPTH(OPERATOR_DEPTH)) u_stacks (
    .clk, .v_we, .v_waddr, .v_wdata, .v_raddr, .v_rdata,
    .o_we, .o_waddr, .o_wdata, .o_raddr, .o_rdata
  );

  iee_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  assign in_stall   = (state_r != S_IDLE);
  assign take       = in_valid && !in_stall;
  assign out_valid  = ov_r;
  assign out_value  = oval_r;
  assign out_status = ost_r;
  assign cop        = decode_ch(in_ch);

  always_comb begin
    unique case (top_r)
      OP_ADD:  alu = v_rdata + b_r;
      OP_SUB:  alu = v_rdata - b_r;
      default: alu = v_rdata * b_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vcnt_r  <= '0;
      ocnt_r  <= '0;
      pend_r  <= '0;
      innum_r <= 1'b0;
      err_r   <= ST_OK;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vcnt_r  <= vcnt_nxt;
      ocnt_r  <= ocnt_nxt;
      pend_r  <= pend_nxt;
      innum_r <= innum_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
    op_r   <= op_nxt;
    last_r <= last_nxt;
    top_r  <= top_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    oval_r <= oval_nxt;
    ost_r  <= ost_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (err_r != ST_OK) begin
            state_nxt = in_last ? S_FINAL : S_IDLE;
          end else if (cop == OP_NONE && !in_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RDOP;
          end
        end
      end
      S_RDOP:   state_nxt = S_WAITOP;
      S_WAITOP: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (err_r != ST_OK) begin
          state_nxt = last_r ? S_FINAL : S_IDLE;
        end else if (op_r == OP_OPEN) begin
          state_nxt = last_r ? S_FINAL : S_IDLE;
        end else if (op_r == OP_CLOSE) begin
          if (ocnt_r == '0) begin
            state_nxt = last_r ? S_FINAL : S_IDLE;
          end else if (top_r == OP_OPEN) begin
            state_nxt = last_r ? S_RDOP : S_IDLE;
          end else begin
            state_nxt = S_RDB;
          end
        end else if (op_r == OP_NONE) begin
          if (ocnt_r == '0 || top_r == OP_OPEN) begin
            state_nxt = last_r ? S_FINAL : S_IDLE;
          end else begin
            state_nxt = S_RDB;
          end
        end else if (ocnt_r != '0 && prec_of(top_r) >= prec_of(op_r)) begin
          state_nxt = S_RDB;
        end else begin
          state_nxt = last_r ? S_RDOP : S_IDLE;
        end
      end
      S_RDB:    state_nxt = S_RDA;
      S_RDA:    state_nxt = S_WAITA;
      S_WAITA: begin
        if (top_r == OP_REM || top_r == OP_DIV) begin
          state_nxt = S_DIVRUN;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_DIVRUN: state_nxt = drsp.done ? S_WRITE : S_DIVRUN;
      S_WRITE:  state_nxt = S_RDOP;
      S_FINAL:  state_nxt = S_RDRES;
      S_RDRES:  state_nxt = S_WAITRES;
      S_WAITRES: state_nxt = (ov_r && out_stall) ? S_WAITRES : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
    if (state_r == S_RDB || state_r == S_RDA || state_r == S_WAITA ||
        state_r == S_DIVRUN || state_r == S_WRITE) begin
      if (err_nxt != ST_OK && state_r != S_WRITE) begin
        state_nxt = last_r ? S_FINAL : S_IDLE;
      end
    end
    if (state_r == S_DECIDE && err_nxt != ST_OK) begin
      state_nxt = last_r ? S_FINAL : S_IDLE;
    end
  end

  always_comb begin
    vcnt_nxt  = vcnt_r;
    ocnt_nxt  = ocnt_r;
    pend_nxt  = pend_r;
    innum_nxt = innum_r;
    err_nxt   = err_r;
    op_nxt    = op_r;
    last_nxt  = last_r;
    top_nxt   = top_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && out_stall;
    oval_nxt  = oval_r;
    ost_nxt   = ost_r;
    v_we      = 1'b0;
    v_waddr   = vcnt_r[VW-1:0];
    v_wdata   = pend_r;
    v_raddr   = '0;
    o_we      = 1'b0;
    o_waddr   = ocnt_r[OW-1:0];
    o_wdata   = op_r;
    o_raddr   = '0;
    dreq.start = 1'b0;
    dreq.a     = v_rdata;
    dreq.b     = b_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          last_nxt = in_last;
          op_nxt   = (err_r == ST_OK) ? cop : OP_NONE;
          if (err_r == ST_OK && in_ch >= CH_ZERO && in_ch <= CH_NINE) begin
            pend_nxt  = (pend_r << 3) + (pend_r << 1) + {24'd0, in_ch - CH_ZERO};
            innum_nxt = 1'b1;
            if (in_last) begin
              op_nxt = OP_NONE;
            end
          end
        end
      end
      S_RDOP: begin
        o_raddr = ocnt_r[OW-1:0] - OW'(1);
        if (innum_r && err_r == ST_OK) begin
          if (vcnt_r == (VW+1)'(VALUE_DEPTH)) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            v_we     = 1'b1;
            vcnt_nxt = vcnt_r + (VW+1)'(1);
          end
          innum_nxt = 1'b0;
          pend_nxt  = '0;
        end
      end
      S_WAITOP: top_nxt = o_rdata;
      S_DECIDE: begin
        if (err_r == ST_OK) begin
          if (op_r == OP_OPEN) begin
            if (ocnt_r == (OW+1)'(OPERATOR_DEPTH)) begin
              err_nxt = ST_OVERFLOW;
            end else if (last_r) begin
              err_nxt = ST_MALFORMED;
            end else begin
              o_we = 1'b1;
              ocnt_nxt = ocnt_r + (OW+1)'(1);
            end
          end else if (op_r == OP_CLOSE) begin
            if (ocnt_r == '0) begin
              err_nxt = ST_MALFORMED;
            end else if (top_r == OP_OPEN) begin
              ocnt_nxt = ocnt_r - (OW+1)'(1);
              op_nxt   = OP_NONE;
            end
          end else if (op_r == OP_NONE) begin
            if (ocnt_r != '0 && top_r == OP_OPEN) begin
              err_nxt = ST_MALFORMED;
            end
          end else if (ocnt_r == '0 || prec_of(top_r) < prec_of(op_r)) begin
            if (ocnt_r == (OW+1)'(OPERATOR_DEPTH)) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              o_we = 1'b1;
              ocnt_nxt = ocnt_r + (OW+1)'(1);
              if (last_r) begin
                op_nxt = OP_NONE;
              end
            end
          end
        end
      end
      S_RDB: begin
        if (top_r == OP_OPEN || vcnt_r < (VW+1)'(2)) begin
          err_nxt = ST_MALFORMED;
        end else begin
          v_raddr = vcnt_r[VW-1:0] - VW'(1);
        end
        ocnt_nxt = ocnt_r - (OW+1)'(1);
      end
      S_RDA: begin
        v_raddr = vcnt_r[VW-1:0] - VW'(2);
        b_nxt   = v_rdata;
      end
      S_WAITA: begin
        res_nxt = alu;
        if (top_r == OP_REM || top_r == OP_DIV) begin
          if (b_r == '0) begin
            err_nxt = ST_DIVZERO;
          end else begin
            dreq.start = 1'b1;
          end
        end
      end
      S_DIVRUN: begin
        if (drsp.done) begin
          res_nxt = (top_r == OP_DIV) ? drsp.quo : drsp.rem;
        end
      end
      S_WRITE: begin
        v_we     = 1'b1;
        v_waddr  = vcnt_r[VW-1:0] - VW'(2);
        v_wdata  = res_r;
        vcnt_nxt = vcnt_r - (VW+1)'(1);
      end
      S_FINAL: begin
        if (err_r == ST_OK && vcnt_r != (VW+1)'(1)) begin
          err_nxt = ST_MALFORMED;
        end
      end
      S_RDRES: v_raddr = '0;
      S_WAITRES: begin
        if (!(ov_r && out_stall)) begin
          oval_nxt = (err_r == ST_OK) ? v_rdata : 32'd0;
          ost_nxt  = err_r;
          ov_nxt   = 1'b1;
          vcnt_nxt = '0;
          ocnt_nxt = '0;
          pend_nxt = '0;
          innum_nxt = 1'b0;
          err_nxt  = ST_OK;
        end
      end
      default: ;
    endcase
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_out_ok_zero, out_valid && out_status != ST_OK, out_value == 32'd0,
    "error result carries a nonzero value")
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_value) && $stable(out_status),
    "stalled result beat changed")
  `ASSERT_IMPL(a_counts_bound, 1'b1,
    vcnt_r <= (VW+1)'(VALUE_DEPTH) && ocnt_r <= (OW+1)'(OPERATOR_DEPTH),
    "stack count beyond depth")
endmodule

// ===== hdl/iee_div.sv =====
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
module iee_div (
  input  logic              clk,
  input  logic              rst_n,
  input  iee_pkg::div_req_t req,
  output iee_pkg::div_rsp_t rsp
);
  import iee_pkg::*;

  logic        busy_r, done_r, sa_r, sq_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r, r_r, d_r;
  logic [31:0] ma, mb;
  logic [32:0] trial;

  assign ma = req.a[31] ? 32'd0 - req.a : req.a;
  assign mb = req.b[31] ? 32'd0 - req.b : req.b;
  assign trial = {r_r, q_r[31]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= ma;
        r_r    <= '0;
        d_r    <= mb;
        sa_r   <= req.a[31];
        sq_r   <= req.a[31] ^ req.b[31];
      end else if (busy_r) begin
        if (!trial[32]) begin
          r_r <= trial[31:0];
          q_r <= {q_r[30:0], 1'b1};
        end else begin
          r_r <= {r_r[30:0], q_r[31]};
          q_r <= {q_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = sq_r ? 32'd0 - q_r : q_r;
  assign rsp.rem  = sa_r ? 32'd0 - r_r : r_r;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_div_done_ends_busy, busy_r && cnt_r == 5'd31, done_r && !busy_r,
    "divider did not finish after 32 steps")
  `ASSERT_IMPL(a_div_done_not_busy, done_r, !busy_r, "divider done while busy")
  `ASSERT_IMPL(a_div_idle_count, !busy_r, cnt_r == 5'd0, "divider step count not cleared")
endmodule

// ===== hdl/iee_stacks.sv =====
// Value and operator stack memories with one write port and registered read each.
module iee_stacks #(
  parameter int VALUE_DEPTH    = 16,
  parameter int OPERATOR_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              v_we,
  input  logic [$clog2(VALUE_DEPTH)-1:0]    v_waddr,
  input  logic [31:0]                       v_wdata,
  input  logic [$clog2(VALUE_DEPTH)-1:0]    v_raddr,
  output logic [31:0]                       v_rdata,
  input  logic                              o_we,
  input  logic [$clog2(OPERATOR_DEPTH)-1:0] o_waddr,
  input  logic [2:0]                        o_wdata,
  input  logic [$clog2(OPERATOR_DEPTH)-1:0] o_raddr,
  output logic [2:0]                        o_rdata
);
  logic [31:0] vmem [VALUE_DEPTH];
  logic [2:0]  omem [OPERATOR_DEPTH];

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    v_rdata <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (o_we) begin
      omem[o_waddr] <= o_wdata;
    end
    o_rdata <= omem[o_raddr];
  end
endmodule

// ===== tb/infix_expression_evaluator_checker.sv =====
// Checker that predicts each expression result from the accepted characters and compares it.
module infix_expression_evaluator_checker #(
  parameter int VALUE_DEPTH    = 16,
  parameter int OPERATOR_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_value,
  input  logic [1:0]         out_status,
  output int                 fail_count,
  output int                 waiting,
  output int                 result_count
);
  import iee_pkg::*;

  logic [31:0] value_mem [VALUE_DEPTH];
  op_t         op_mem [OPERATOR_DEPTH];
  int          value_top;
  int          op_top;
  logic [31:0] number_acc;
  bit          number_open;
  status_t     sticky_status;

  logic [31:0] expected_value_q [$];
  status_t     expected_status_q [$];

  function automatic int op_rank(input op_t o);
    case (o)
      OP_ADD, OP_SUB: return 1;
      OP_REM:         return 2;
      OP_MUL, OP_DIV: return 3;
      default:        return 0;
    endcase
  endfunction

  task automatic raise(input status_t s);
    if (sticky_status == ST_OK) sticky_status = s;
  endtask

  task automatic clear_state();
    value_top     = 0;
    op_top        = 0;
    number_acc    = '0;
    number_open   = 0;
    sticky_status = ST_OK;
  endtask

  task automatic push_value(input logic [31:0] v);
    if (value_top >= VALUE_DEPTH) begin
      raise(ST_OVERFLOW);
    end else begin
      value_mem[value_top] = v;
      value_top++;
    end
  endtask

  task automatic push_op(input op_t o);
    if (op_top >= OPERATOR_DEPTH) begin
      raise(ST_OVERFLOW);
    end else begin
      op_mem[op_top] = o;
      op_top++;
    end
  endtask

  task automatic apply_op(input logic [31:0] a, input logic [31:0] b, input op_t o,
                          output logic [31:0] r);
    logic [31:0] ma, mb, q, m;
    case (o)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      default: begin
        if (b == 0) begin
          raise(ST_DIVZERO);
          r = '0;
        end else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q  = ma / mb;
          m  = ma % mb;
          if (o == OP_DIV) r = (a[31] ^ b[31]) ? -q : q;
          else r = a[31] ? -m : m;
        end
      end
    endcase
  endtask

  task automatic reduce_top();
    op_t o;
    logic [31:0] a, b, r;
    if (op_top == 0) begin
      raise(ST_MALFORMED);
    end else begin
      op_top--;
      o = op_mem[op_top];
      if (o == OP_OPEN || value_top < 2) begin
        raise(ST_MALFORMED);
      end else begin
        b = value_mem[value_top - 1];
        a = value_mem[value_top - 2];
        value_top -= 2;
        apply_op(a, b, o, r);
        if (sticky_status == ST_OK) begin
          value_mem[value_top] = r;
          value_top++;
        end
      end
    end
  endtask

  task automatic close_number();
    if (number_open) begin
      push_value(number_acc);
      number_open = 0;
      number_acc  = '0;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    op_t o;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      number_acc  = number_acc * 10 + (c - CH_ZERO);
      number_open = 1;
      return;
    end
    case (c)
      CH_OPEN:  o = OP_OPEN;
      CH_CLOSE: o = OP_CLOSE;
      CH_PLUS:  o = OP_ADD;
      CH_MINUS: o = OP_SUB;
      CH_PCT:   o = OP_REM;
      CH_STAR:  o = OP_MUL;
      CH_SLASH: o = OP_DIV;
      default:  return;
    endcase
    close_number();
    if (sticky_status != ST_OK) return;
    if (o == OP_OPEN) begin
      push_op(OP_OPEN);
    end else if (o == OP_CLOSE) begin
      while (sticky_status == ST_OK && op_top > 0 && op_mem[op_top - 1] != OP_OPEN)
        reduce_top();
      if (sticky_status != ST_OK) return;
      if (op_top == 0) raise(ST_MALFORMED);
      else op_top--;
    end else begin
      while (sticky_status == ST_OK && op_top > 0 && op_rank(op_mem[op_top - 1]) >= op_rank(o))
        reduce_top();
      if (sticky_status == ST_OK) push_op(o);
    end
  endtask

  task automatic finish_expression();
    logic [31:0] v;
    v = '0;
    if (sticky_status == ST_OK) close_number();
    while (sticky_status == ST_OK && op_top > 0) reduce_top();
    if (sticky_status == ST_OK && value_top != 1) raise(ST_MALFORMED);
    if (sticky_status == ST_OK) v = value_mem[0];
    expected_value_q.push_back(v);
    expected_status_q.push_back(sticky_status);
    clear_state();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      expected_value_q.delete();
      expected_status_q.delete();
      fail_count   <= 0;
      waiting      <= 0;
      result_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_value_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: value %0d status %0d",
                   $time, out_value, out_status);
          fail_count <= fail_count + 1;
        end else begin
          if (out_value !== expected_value_q[0] || out_status !== expected_status_q[0]) begin
            $display("%0t: mismatch: expected value %0d status %0d, got value %0d status %0d",
                     $time, $signed(expected_value_q[0]), expected_status_q[0],
                     out_value, out_status);
            fail_count <= fail_count + 1;
          end
          void'(expected_value_q.pop_front());
          void'(expected_status_q.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        if (sticky_status == ST_OK) take_char(in_ch);
        if (in_last) finish_expression();
      end
      waiting <= expected_value_q.size();
    end
  end

endmodule

// ===== tb/infix_expression_evaluator_test.sv =====
// Testbench top that drives expression characters into the evaluator and gives the verdict.
module infix_expression_evaluator_test;
  import iee_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int CHAR_TARGET = 1800;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_ch;
  logic               in_last;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_value;
  logic [1:0]         out_status;
  int                 fail_count;
  int                 waiting;
  int                 result_count;
  int                 cycle_count;
  int                 chars_sent;
  int                 expressions_sent;
  int                 burst_left;
  bit                 steady;

  infix_expression_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_status(out_status)
  );

  infix_expression_evaluator_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_status(out_status),
    .fail_count(fail_count), .waiting(waiting), .result_count(result_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("FAIL infix_expression_evaluator");
      $finish;
    end
  end

  // The receiver switches at random among four stall patterns.
  int stall_mode;
  always @(posedge clk) begin
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  function automatic bit is_token(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_OPEN || c == CH_CLOSE ||
           c == CH_PLUS || c == CH_MINUS || c == CH_PCT || c == CH_STAR || c == CH_SLASH;
  endfunction

  function automatic logic [7:0] ignored_char();
    logic [7:0] c;
    c = $urandom_range(0, 255);
    while (is_token(c)) c = $urandom_range(0, 255);
    return c;
  endfunction

  function automatic string rand_number();
    string s;
    int len, pick;
    s = "";
    pick = $urandom_range(0, 9);
    len = pick < 6 ? $urandom_range(1, 2) : pick < 9 ? $urandom_range(3, 5)
                                                      : $urandom_range(6, 12);
    repeat (len) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  function automatic string rand_expr(input int depth);
    string s, opchars;
    int k;
    s = "";
    opchars = "+-%*/";
    for (int i = 0; i < $urandom_range(1, 4); i++) begin
      if (i > 0) begin
        k = $urandom_range(0, 4);
        s = {s, opchars.substr(k, k)};
      end
      if (depth > 0 && $urandom_range(0, 3) == 0) s = {s, "(", rand_expr(depth - 1), ")"};
      else s = {s, rand_number()};
    end
    return s;
  endfunction

  function automatic string broken_expr();
    string s, alphabet;
    int k;
    s = "";
    alphabet = "0123456789+-*/%()";
    repeat ($urandom_range(1, 8)) begin
      k = $urandom_range(0, 16);
      s = {s, alphabet.substr(k, k)};
    end
    return s;
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic fin);
    if (!steady && burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1;
    in_ch    <= c;
    in_last  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    chars_sent++;
  endtask

  task automatic send_expr(input string s, input bit noisy);
    bit tail;
    tail = (s.len() == 0) || ($urandom_range(0, 11) == 0);
    for (int i = 0; i < s.len(); i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_beat(ignored_char(), 0);
      send_beat(s[i], !tail && i == s.len() - 1);
    end
    if (tail) send_beat(ignored_char(), 1);
    expressions_sent++;
  endtask

  initial begin
    string s;
    int pick;
    rst_n = 0;
    in_valid = 0;
    in_ch = '0;
    in_last = 0;
    chars_sent = 0;
    expressions_sent = 0;
    burst_left = 0;
    steady = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    send_expr("2147483647+1", 0);
    send_expr("(0-2147483647-1)/(0-1)", 0);
    send_expr("(0-2147483647-1)%(0-1)", 0);
    send_expr("(0-7)%2*3+(0-7)/2", 0);
    send_expr("7/0", 0);
    send_expr("7%0+1", 0);
    send_expr("99999999999", 0);
    send_expr("2+3*4%5-6/2", 0);
    send_expr("(1+2", 0);
    send_expr("1+2)", 0);
    send_expr("", 0);
    send_expr("1+", 0);
    send_expr("1 2#3", 0);
    s = "";
    repeat (17) s = {s, "("};
    send_expr(s, 0);
    s = "";
    repeat (16) s = {s, "("};
    repeat (17) s = {s, "1)"};
    send_expr(s, 0);

    while (chars_sent < CHAR_TARGET) begin
      if (expressions_sent % 40 == 0) steady = ~steady;
      if (expressions_sent == 60) begin
        in_valid <= 0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) send_expr(broken_expr(), 1);
      else send_expr(rand_expr(3), pick < 3);
    end
    in_valid <= 0;
    in_last  <= 0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d expressions in %0d characters, with noise, broken input and",
             expressions_sent, chars_sent);
    $display("every error kind; %0d results were compared.", result_count);
    if (fail_count == 0) begin
      $display("PASS infix_expression_evaluator");
    end else begin
      $display("FAIL infix_expression_evaluator");
    end
    $finish;
  end

endmodule
